// ===== hw/rtl/bdeque_pkg.sv =====
// bdeque_pkg: word types, request codes and status codes of the bounded deque
// used by bounded_deque_with_delete; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdeque_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [2:0] K_PUSH_BACK  = 3'd0;
  localparam logic [2:0] K_POP_BACK   = 3'd1;
  localparam logic [2:0] K_PUSH_FRONT = 3'd2;
  localparam logic [2:0] K_POP_FRONT  = 3'd3;
  localparam logic [2:0] K_DELETE     = 3'd4;
  localparam logic [2:0] K_COUNT      = 3'd5;
  localparam logic [2:0] K_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [CNT_W-1:0]   occupancy;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_delete.sv =====
// bounded_deque_with_delete: 16-entry double-ended queue of signed words with
// delete-first-match; circular buffer in a one-read, one-write memory
// depends on bdeque_pkg
// steps after accept: push, count and clear run an execute step and an emit step, pops
//   add a memory read step, and delete searches, then moves entries one by one, before emit
// one request at a time: a new request is taken only once the previous result is registered;
//   one sequencer on one read port, an untaken result stalls it
// reset: synchronous, clears count, front slot, sequencer and out_valid; entries are
//   not cleared
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_delete
  import bdeque_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  hole_r, hole_nxt;
  logic [2:0]        kind_r;
  logic [31:0]       val_r;
  logic [31:0]       res_popped_r, res_popped_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_r, out_nxt;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data_r;
  logic [IDX_W-1:0]  rd_slot_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [31:0]       mem_wd;

  // shared slot unit: logical position to physical slot
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  slot_sum;
  logic [IDX_W-1:0]  slot;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pos = '0;
    unique case (state_r)
      S_EXEC: begin
        case (kind_r)
          K_PUSH_BACK:  pos = cnt_r;
          K_POP_BACK:   pos = cnt_r - CNT_W'(1);
          K_PUSH_FRONT: pos = CNT_W'(DEPTH - 1);
          default:      pos = '0;
        endcase
      end
      S_POP:   pos = CNT_W'(1);
      S_SRCH:  pos = cur_r + CNT_W'(1);
      S_SHIFT: pos = cur_r + CNT_W'(2);
      default: pos = '0;
    endcase
  end

  // depth is a power of two, so the wrap is the low index bits
  assign slot_sum = {{(CNT_W-IDX_W){1'b0}}, front_r} + pos;
  assign slot     = slot_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[slot];
    rd_slot_r <= slot;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    front_nxt      = front_r;
    cur_nxt        = cur_r;
    hole_nxt       = hole_r;
    res_popped_nxt = res_popped_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_wa         = slot;
    mem_wd         = val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt      = S_EXEC;
          res_popped_nxt = '0;
          res_status_nxt = ST_OK;
          cur_nxt        = '0;
        end
      end
      S_EXEC: begin
        state_nxt = S_EMIT;
        case (kind_r)
          K_PUSH_BACK, K_PUSH_FRONT: begin
            if (cnt_r == CNT_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
              if (kind_r == K_PUSH_FRONT) begin
                front_nxt = slot;
              end
            end
          end
          K_POP_BACK, K_POP_FRONT: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_POP;
            end
          end
          K_DELETE: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_SRCH;
            end
          end
          K_CLEAR: begin
            cnt_nxt   = '0;
            front_nxt = '0;
          end
          default: ;
        endcase
      end
      S_POP: begin
        res_popped_nxt = rd_data_r;
        cnt_nxt        = cnt_r - CNT_W'(1);
        if (kind_r == K_POP_FRONT) begin
          front_nxt = slot;
        end
        state_nxt = S_EMIT;
      end
      S_SRCH: begin
        // rd_data_r holds entry cur_r, entry cur_r + 1 is being read
        if (rd_data_r == val_r) begin
          hole_nxt = rd_slot_r;
          if (cur_r + CNT_W'(1) < cnt_r) begin
            state_nxt = S_SHIFT;
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_EMIT;
          end
        end else if (cur_r + CNT_W'(1) < cnt_r) begin
          cur_nxt = cur_r + CNT_W'(1);
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end
      end
      S_SHIFT: begin
        // move the next word into the hole, its old slot becomes the hole
        mem_we   = 1'b1;
        mem_wa   = hole_r;
        mem_wd   = rd_data_r;
        hole_nxt = rd_slot_r;
        if (cur_r + CNT_W'(2) < cnt_r) begin
          cur_nxt = cur_r + CNT_W'(1);
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.popped    = res_popped_r;
          out_nxt.occupancy = cnt_r;
          out_nxt.status    = res_status_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_data.kind;
      val_r  <= in_data.value;
    end
    cur_r        <= cur_nxt;
    hole_r       <= hole_nxt;
    res_popped_r <= res_popped_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ({1'b0, cur_r} + (CNT_W+1)'(1) < {1'b0, cnt_r}))
    else $error("compaction reads beyond the held entries");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result word raised outside the emit step");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not remove one entry");
`endif

endmodule

`default_nettype wire
